>>> hw/rtl/trilinear_field_gather_assert.svh
// Assertion macros used by the block's RTL file trilinear_field_gather.sv.
`ifndef TRILINEAR_FIELD_GATHER_ASSERT_SVH
`define TRILINEAR_FIELD_GATHER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TFG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trilinear_field_gather: check failed");

// The consequent holds in the cycle after the antecedent.
`define TFG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trilinear_field_gather: check failed");

`endif

>>> hw/rtl/tfg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfg_pkg;

	localparam int NCOMP = 15;
	localparam int S_TDATA_W = 144;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [3:0] LAST_COMP = 4'd14;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_GATHER = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_Z    = 3'd5;

	localparam logic [31:0] INV_RESET = 32'd65536;
	localparam logic signed [63:0] SAT_LIMIT = 64'sh7FFF_FFFF_8000_0000;
	localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;
	localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIFF,
		S_MLO,
		S_MHI,
		S_MAX,
		S_WXY,
		S_WGT,
		S_MAC,
		S_SAT
	} tfg_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/trilinear_field_gather.sv
`timescale 1ns / 1ps
`default_nettype none

// Trilinear field gather. Words with s_tuser = 0 store one Q16.16 component of one grid node
// and give no result. A word with s_tuser = 1 gives a particle position and produces fifteen
// result words, one per component, with tlast on the fifteenth; a position whose cell lies
// outside the grid gives zero values with the out-of-grid flag set. The block is not ready
// for a new word until a gather is done: one shared multiplier does the axis mapping, the
// corner weights and the weighted sums, and the single read port of the node store delivers
// the eight corners of each component. The node store is not cleared at reset; a component
// that was never written reads as an undefined value. Configuration writes are taken at any
// time and must only be issued while the block is idle.
module trilinear_field_gather #(
	parameter int GRID_SIZE = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// node_x, node_y, node_z, component, node_value, pos_x, pos_y, pos_z
	input  wire logic [tfg_pkg::S_TDATA_W-1:0]   s_tdata,
	// opcode
	input  wire logic [tfg_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// out_value
	output logic      [tfg_pkg::M_TDATA_W-1:0]   m_tdata,
	// out_component, out_of_grid
	output logic      [tfg_pkg::M_TUSER_W-1:0]   m_tuser,
	output logic                                 m_tlast,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tfg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                     cfg_data
);
	import tfg_pkg::*;

	localparam int CW = $clog2(GRID_SIZE);
	localparam int DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE * NCOMP;
	localparam int AW = $clog2(DEPTH);

	function automatic logic [16:0] axis_wgt(input logic [15:0] f, input logic hi);
		logic [16:0] fe;
		fe = {1'b0, f};
		return hi ? fe : (17'h10000 - fe);
	endfunction

	function automatic logic [AW-1:0] node_addr(input logic [AW-1:0] x, input logic [AW-1:0] y,
			input logic [AW-1:0] z, input logic [AW-1:0] k);
		return ((z * AW'(GRID_SIZE) + y) * AW'(GRID_SIZE) + x) * AW'(NCOMP) + k;
	endfunction

	tfg_state_t state_q, state_d;

	logic signed [31:0] origin_q [3];
	logic        [31:0] inv_q [3];
	logic        [31:0] pos_q [3];
	logic        [1:0]  ax_q;
	logic        [3:0]  st_q;
	logic        [3:0]  comp_q;
	logic        [32:0] mag_q;
	logic               neg_q;
	logic        [47:0] lo_q;
	logic        [CW-1:0] cell_q [3];
	logic        [15:0] frac_q [3];
	logic               inside_q;
	logic        [32:0] wxy_q [4];
	logic        [32:0] wgt_q [8];
	logic signed [63:0] acc_q;
	logic        [31:0] rdata_q;
	logic signed [66:0] mul_p_q;

	logic        [31:0] mem [DEPTH];

	logic        [31:0] out_value_q;
	logic        [3:0]  out_comp_q;
	logic               out_oog_q;
	logic               out_last_q;
	logic               m_valid_q;

	logic signed [33:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [32:0] diff;
	logic        [64:0] prod65;
	logic        [32:0] idx;
	logic               bad;
	logic        [2:0]  wi;
	logic        [2:0]  corner;
	logic        [AW-1:0] raddr;
	logic        [AW-1:0] waddr;
	logic               s_fire;
	logic               we;
	logic               out_free;
	logic               load_out;
	logic        [63:0] rnd;
	logic        [31:0] sat_val;

	assign s_fire = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign wi = st_q[2:0] - 3'd1;
	assign corner = st_q[2:0];

	assign diff = {pos_q[ax_q][31], pos_q[ax_q]} - {origin_q[ax_q][31], origin_q[ax_q]};
	assign prod65 = {mul_p_q[48:0], 16'b0} + {17'b0, lo_q};
	assign idx = prod65[64:32];
	assign bad = (neg_q && (prod65 != 65'd0)) || (idx > 33'(GRID_SIZE - 2));

	assign raddr = node_addr(AW'(cell_q[0]) + AW'(corner[0]), AW'(cell_q[1]) + AW'(corner[1]),
		AW'(cell_q[2]) + AW'(corner[2]), AW'(comp_q));
	assign waddr = node_addr(AW'(s_tdata[3:0]), AW'(s_tdata[7:4]), AW'(s_tdata[11:8]),
		AW'(s_tdata[15:12]));

	assign rnd = acc_q + ROUND_HALF;
	assign sat_val = (acc_q >= SAT_LIMIT) ? VALUE_MAX : rnd[63:32];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && (s_tuser[0] == OP_GATHER)) state_d = S_DIFF;
			end
			S_DIFF: state_d = S_MLO;
			S_MLO: state_d = S_MHI;
			S_MHI: state_d = S_MAX;
			S_MAX: state_d = (ax_q == 2'd2) ? S_WXY : S_DIFF;
			S_WXY: begin
				if (st_q == 4'd4) state_d = S_WGT;
			end
			S_WGT: begin
				if (st_q == 4'd8) state_d = inside_q ? S_MAC : S_SAT;
			end
			S_MAC: begin
				if (st_q == 4'd9) state_d = S_SAT;
			end
			S_SAT: begin
				if (out_free) begin
					if (comp_q == LAST_COMP) state_d = S_IDLE;
					else state_d = inside_q ? S_MAC : S_SAT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == S_IDLE);
		load_out = (state_q == S_SAT) && out_free;
		we = s_fire && (s_tuser[0] == OP_WRITE) && (s_tdata[15:12] <= LAST_COMP)
			&& ({28'b0, s_tdata[3:0]} < 32'(GRID_SIZE))
			&& ({28'b0, s_tdata[7:4]} < 32'(GRID_SIZE))
			&& ({28'b0, s_tdata[11:8]} < 32'(GRID_SIZE));
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MLO: begin
				mul_a = 34'(mag_q[15:0]);
				mul_b = {1'b0, inv_q[ax_q]};
			end
			S_MHI: begin
				mul_a = 34'(mag_q[32:16]);
				mul_b = {1'b0, inv_q[ax_q]};
			end
			S_WXY: begin
				mul_a = 34'(axis_wgt(frac_q[0], st_q[0]));
				mul_b = 33'(axis_wgt(frac_q[1], st_q[1]));
			end
			S_WGT: begin
				mul_a = {1'b0, wxy_q[st_q[1:0]]};
				mul_b = 33'(axis_wgt(frac_q[2], st_q[2]));
			end
			S_MAC: begin
				mul_a = {1'b0, wgt_q[wi]};
				mul_b = {rdata_q[31], rdata_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= '0;
			ax_q <= '0;
			comp_q <= '0;
			inside_q <= 1'b0;
			m_valid_q <= 1'b0;
			origin_q[0] <= '0;
			origin_q[1] <= '0;
			origin_q[2] <= '0;
			inv_q[0] <= INV_RESET;
			inv_q[1] <= INV_RESET;
			inv_q[2] <= INV_RESET;
		end else begin
			state_q <= state_d;
			st_q <= (state_q != state_d) ? 4'd0 : st_q + 4'd1;
			if (s_fire) begin
				ax_q <= '0;
				comp_q <= '0;
				inside_q <= 1'b1;
			end
			if (state_q == S_MAX) begin
				ax_q <= ax_q + 2'd1;
				inside_q <= inside_q && !bad;
			end
			if (load_out) comp_q <= comp_q + 4'd1;
			if (load_out) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ORIGIN_X: origin_q[0] <= cfg_data;
					REG_ORIGIN_Y: origin_q[1] <= cfg_data;
					REG_ORIGIN_Z: origin_q[2] <= cfg_data;
					REG_INV_X: inv_q[0] <= cfg_data;
					REG_INV_Y: inv_q[1] <= cfg_data;
					REG_INV_Z: inv_q[2] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		if (s_fire) begin
			pos_q[0] <= s_tdata[79:48];
			pos_q[1] <= s_tdata[111:80];
			pos_q[2] <= s_tdata[143:112];
		end
		if (state_q == S_DIFF) begin
			neg_q <= diff[32];
			mag_q <= diff[32] ? 33'(-diff) : 33'(diff);
		end
		if (state_q == S_MHI) lo_q <= mul_p_q[47:0];
		if (state_q == S_MAX) begin
			cell_q[ax_q] <= idx[CW-1:0];
			frac_q[ax_q] <= prod65[31:16];
		end
		if ((state_q == S_WXY) && (st_q != 4'd0)) wxy_q[st_q[1:0] - 2'd1] <= mul_p_q[32:0];
		if ((state_q == S_WGT) && (st_q != 4'd0)) wgt_q[wi] <= mul_p_q[48:16];
		if (state_q == S_MAC) begin
			if (st_q == 4'd0) acc_q <= '0;
			else if (st_q >= 4'd2) acc_q <= acc_q + mul_p_q[63:0];
		end
		if (load_out) begin
			out_value_q <= inside_q ? sat_val : 32'd0;
			out_comp_q <= comp_q;
			out_oog_q <= !inside_q;
			out_last_q <= (comp_q == LAST_COMP);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= s_tdata[47:16];
		rdata_q <= mem[raddr];
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid = m_valid_q;
	assign m_tdata = out_value_q;
	assign m_tuser = {out_oog_q, out_comp_q};
	assign m_tlast = out_last_q;

`include "trilinear_field_gather_assert.svh"

	`TFG_ASSERT_NOW(a_oog_zero, m_tvalid && m_tuser[4], m_tdata == 32'd0)
	`TFG_ASSERT_NOW(a_last_comp, m_tvalid && m_tlast, m_tuser[3:0] == LAST_COMP)
	`TFG_ASSERT_NEXT(a_gather_busy, s_tvalid && s_tready && (s_tuser[0] == OP_GATHER), !s_tready)
	`TFG_ASSERT_NOW(a_comp_range, state_q != S_IDLE, comp_q <= LAST_COMP)

endmodule

`default_nettype wire

>>> dv/trilinear_field_gather_test.sv
`timescale 1ns / 1ps

module trilinear_field_gather_test;
	import tfg_pkg::*;

	localparam int GRID = 16;
	localparam int STORE_DEPTH = GRID * GRID * GRID * NCOMP;

	typedef struct {
		logic [3:0]  comp;
		logic [31:0] value;
		logic        oog;
		logic        last;
	} field_sample_t;

	typedef struct {
		logic        op;
		logic [3:0]  x, y, z, comp;
		logic [31:0] value, px, py, pz;
		bit          typed_oog;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic [31:0] node_mem [0:STORE_DEPTH-1];
	bit written [0:STORE_DEPTH-1];
	logic [31:0] origin [3];
	logic [31:0] inv_sp [3];
	field_sample_t pending_fields [$];
	stim_row_t dir_tab [$];
	int errors = 0;
	int gathers = 0;
	int writes = 0;
	int results = 0;
	int oog_results = 0;
	bit quiet = 1'b0;

	trilinear_field_gather #(.GRID_SIZE(GRID)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("trilinear_field_gather_test failed");
		$finish;
	end

	function automatic bit grid_axis(input logic [31:0] pos, input logic [31:0] org,
			input logic [31:0] inv, output int unsigned cidx, output logic [15:0] fr);
		longint diff;
		logic [63:0] mag, prod;
		diff = longint'($signed(pos)) - longint'($signed(org));
		mag = (diff < 0) ? 64'(-diff) : 64'(diff);
		prod = mag * {32'd0, inv};
		cidx = 0;
		fr = '0;
		if (diff < 0 && prod != 0)
			return 1'b0;
		if (prod[63:32] > GRID - 2)
			return 1'b0;
		cidx = prod[63:32];
		fr = prod[31:16];
		return 1'b1;
	endfunction

	function automatic int unsigned store_addr(int unsigned x, int unsigned y,
			int unsigned z, int unsigned c);
		return ((z * GRID + y) * GRID + x) * NCOMP + c;
	endfunction

	// A gather is only sent when every component it reads has been set.
	function automatic bit reads_set(input stim_row_t r);
		int unsigned cidx [3];
		logic [15:0] fr [3];
		logic [31:0] pos [3];
		pos[0] = r.px;
		pos[1] = r.py;
		pos[2] = r.pz;
		if (r.op == OP_WRITE)
			return 1'b1;
		for (int a = 0; a < 3; a++)
			if (!grid_axis(pos[a], origin[a], inv_sp[a], cidx[a], fr[a]))
				return 1'b1;
		for (int c = 0; c < 8; c++)
			for (int k = 0; k < NCOMP; k++)
				if (!written[store_addr(cidx[0] + c[0], cidx[1] + c[1], cidx[2] + c[2], k)])
					return 1'b0;
		return 1'b1;
	endfunction

	task automatic predict_gather(input logic [31:0] px, py, pz);
		int unsigned cidx [3];
		logic [15:0] fr [3];
		logic [31:0] pos [3];
		logic [63:0] w [8];
		logic [63:0] wx, wy, wz;
		logic [63:0] rounded;
		longint acc;
		bit in_grid;
		field_sample_t e;
		pos[0] = px;
		pos[1] = py;
		pos[2] = pz;
		in_grid = 1'b1;
		for (int a = 0; a < 3; a++)
			if (!grid_axis(pos[a], origin[a], inv_sp[a], cidx[a], fr[a]))
				in_grid = 1'b0;
		for (int c = 0; c < 8; c++) begin
			wx = c[0] ? 64'(fr[0]) : 64'd65536 - 64'(fr[0]);
			wy = c[1] ? 64'(fr[1]) : 64'd65536 - 64'(fr[1]);
			wz = c[2] ? 64'(fr[2]) : 64'd65536 - 64'(fr[2]);
			w[c] = (wx * wy * wz) >> 16;
		end
		for (int k = 0; k < NCOMP; k++) begin
			e.comp = 4'(k);
			e.oog = !in_grid;
			e.last = (4'(k) == LAST_COMP);
			e.value = '0;
			if (in_grid) begin
				acc = 0;
				for (int c = 0; c < 8; c++)
					acc += longint'(w[c]) * longint'($signed(node_mem[store_addr(
						cidx[0] + c[0], cidx[1] + c[1], cidx[2] + c[2], k)]));
				if (acc >= SAT_LIMIT) begin
					e.value = VALUE_MAX;
				end else begin
					rounded = 64'(acc) + ROUND_HALF;
					e.value = rounded[63:32];
				end
			end
			pending_fields.push_back(e);
		end
	endtask

	task automatic send_word(input stim_row_t r);
		s_tvalid <= 1'b1;
		s_tdata <= {r.pz, r.py, r.px, r.value, r.comp, r.z, r.y, r.x};
		s_tuser <= r.op;
		do @(posedge clk); while (!s_tready);
		if (r.op == OP_WRITE) begin
			writes++;
			if (r.comp <= LAST_COMP) begin
				node_mem[store_addr(r.x, r.y, r.z, r.comp)] = r.value;
				written[store_addr(r.x, r.y, r.z, r.comp)] = 1'b1;
			end
		end else begin
			gathers++;
			if (r.typed_oog) begin
				for (int k = 0; k < NCOMP; k++)
					pending_fields.push_back('{4'(k), 32'd0, 1'b1, 4'(k) == LAST_COMP});
			end else begin
				predict_gather(r.px, r.py, r.pz);
			end
		end
	endtask

	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 99) < 8) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_fields.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx < 3)
			origin[idx] = data;
		else
			inv_sp[idx - 3] = data;
	endtask

	// Positions cluster around the first or the last cell of the grid.
	function automatic logic [31:0] near_pos(int a, bit hi);
		logic [63:0] sp, span, off, base;
		if ($urandom_range(0, 99) < 15 || inv_sp[a] == 0)
			return $urandom;
		sp = 64'h1_0000_0000 / inv_sp[a];
		base = hi ? sp * 64'(GRID - 2) : 64'd0;
		span = sp * 2 + sp / 4 + 1;
		off = {$urandom, $urandom} % span;
		return origin[a] + 32'(base + off - sp / 4);
	endfunction

	function automatic stim_row_t random_row(bit gather);
		stim_row_t r;
		bit hi;
		hi = 1'($urandom_range(0, 1));
		r.op = gather ? OP_GATHER : OP_WRITE;
		r.x = 4'($urandom);
		r.y = 4'($urandom);
		r.z = 4'($urandom);
		r.comp = 4'($urandom_range(0, 15));
		r.value = $urandom;
		r.px = gather ? near_pos(0, hi) : $urandom;
		r.py = gather ? near_pos(1, hi) : $urandom;
		r.pz = gather ? near_pos(2, hi) : $urandom;
		r.typed_oog = 1'b0;
		return r;
	endfunction

	always @(posedge clk)
		m_tready <= quiet || $urandom_range(0, 99) >= 8;

	always @(posedge clk) begin
		field_sample_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results++;
			if (m_tuser[4])
				oog_results++;
			if (pending_fields.size() == 0) begin
				errors++;
				$display("%0t: unexpected word value %h user %h last %b",
					$time, m_tdata, m_tuser, m_tlast);
			end else begin
				e = pending_fields.pop_front();
				if (m_tuser[3:0] !== e.comp || m_tdata !== e.value
						|| m_tuser[4] !== e.oog || m_tlast !== e.last) begin
					errors++;
					$display("%0t: expected comp %0d value %h oog %b last %b, got %0d %h %b %b",
						$time, e.comp, e.value, e.oog, e.last,
						m_tuser[3:0], m_tdata, m_tuser[4], m_tlast);
				end
			end
		end
	end

	initial begin
		logic [31:0] phase_cfg [4][6];
		stim_row_t r;
		bit g;
		int tries;
		origin = '{32'd0, 32'd0, 32'd0};
		inv_sp = '{INV_RESET, INV_RESET, INV_RESET};
		phase_cfg[0] = '{32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536, 32'd65536};
		phase_cfg[1] = '{32'hFFFA_8000, 32'h0002_4000, 32'h8000_0000,
			32'd131072, 32'd32768, 32'd196608};
		phase_cfg[2] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
			32'd0, 32'hFFFF_FFFF, 32'd1};
		phase_cfg[3] = '{$urandom, $urandom, $urandom,
			$urandom_range(16384, 262144), $urandom_range(16384, 262144),
			$urandom_range(16384, 262144)};

		dir_tab.push_back('{OP_WRITE, 4'd0, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF, 0, 0, 0, 0});
		dir_tab.push_back('{OP_WRITE, 4'd0, 4'd0, 4'd0, 4'd1, 32'h8000_0000, 0, 0, 0, 0});
		dir_tab.push_back('{OP_WRITE, 4'd15, 4'd15, 4'd15, 4'd14, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0});
		dir_tab.push_back('{OP_WRITE, 4'd1, 4'd1, 4'd1, 4'd15, 32'h1234_5678, 0, 0, 0, 0});
		dir_tab.push_back('{OP_WRITE, 4'd1, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF, 0, 0, 0, 0});
		dir_tab.push_back('{OP_GATHER, 0, 0, 0, 0, 0, 32'd0, 32'd0, 32'd0, 0});
		dir_tab.push_back('{OP_GATHER, 4'hF, 4'hF, 4'hF, 4'hF, 32'hFFFF_FFFF,
			32'h0000_8000, 32'd0, 32'd0, 0});
		dir_tab.push_back('{OP_GATHER, 0, 0, 0, 0, 0,
			32'h000E_FFFF, 32'h000E_FFFF, 32'h000E_FFFF, 0});
		dir_tab.push_back('{OP_GATHER, 0, 0, 0, 0, 0,
			32'h000E_8000, 32'h000E_8000, 32'h000E_8000, 0});
		dir_tab.push_back('{OP_GATHER, 0, 0, 0, 0, 0, 32'h000F_0000, 32'd0, 32'd0, 1});
		dir_tab.push_back('{OP_GATHER, 0, 0, 0, 0, 0, 32'd0, 32'hFFFF_FFFF, 32'd0, 1});
		dir_tab.push_back('{OP_GATHER, 0, 0, 0, 0, 0, 32'd0, 32'd0, 32'h7FFF_FFFF, 1});
		dir_tab.push_back('{OP_GATHER, 0, 0, 0, 0, 0,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1});
		dir_tab.push_back('{OP_GATHER, 0, 0, 0, 0, 0,
			32'h0000_1234, 32'h0000_FEDC, 32'h0000_0001, 0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Set every component at the corners of the first and the last cell.
		quiet = 1'b1;
		for (int blk = 0; blk < 2; blk++)
			for (int z = 0; z < 2; z++)
				for (int y = 0; y < 2; y++)
					for (int x = 0; x < 2; x++)
						for (int c = 0; c < NCOMP; c++) begin
							r = random_row(1'b0);
							r.x = 4'(blk * (GRID - 2) + x);
							r.y = 4'(blk * (GRID - 2) + y);
							r.z = 4'(blk * (GRID - 2) + z);
							r.comp = 4'(c);
							send_word(r);
						end
		quiet = 1'b0;

		foreach (dir_tab[i]) begin
			send_word(dir_tab[i]);
			sender_gap();
		end
		drain_and_settle();

		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < 6; i++)
				write_reg(CFG_IDX_W'(i), phase_cfg[ph][i]);
			cfg_valid <= 1'b0;
			for (int n = 0; n < 40; n++) begin
				quiet = (ph == 1 && n >= 5 && n < 35);
				g = ($urandom_range(0, 99) < 45);
				r = random_row(g);
				tries = 0;
				while (!reads_set(r) && tries < 200) begin
					r = random_row(g);
					tries++;
				end
				if (!reads_set(r))
					r.op = OP_WRITE;
				send_word(r);
				sender_gap();
			end
			quiet = 1'b0;
			drain_and_settle();
		end

		$display("Covered %0d writes and %0d gathers, %0d result words (%0d out of grid).",
			writes, gathers, results, oog_results);
		$display("Configurations included reset values, zero and full-scale spacing, "
			, "extreme origins.");
		if (errors == 0) begin
			$display("trilinear_field_gather_test passed");
		end else begin
			$display("trilinear_field_gather_test failed");
		end
		$finish;
	end

endmodule
